@@ hdl/ptc_pkg.sv @@
`default_nettype none
package ptc_pkg;

  // Field widths
  localparam int unsigned TicksW   = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned SpeedW   = 18;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Divider geometry: 28-bit constant dividend over a 16-bit period
  localparam int unsigned QuotW = 28;
  localparam int unsigned CntW  = $clog2(QuotW);

  localparam logic [QuotW-1:0]   TicksNumerator = QuotW'(160000000);
  localparam logic [SpeedW-1:0]  FakeSpeedX40   = SpeedW'(40000);
  localparam logic [SampleW-1:0] SampleMax      = '1;
  localparam logic [SpeedW-1:0]  SpeedMax       = '1;

  // Register reset values
  localparam logic [TicksW-1:0] MinPeriodReset = TicksW'(4000);
  localparam logic [TicksW-1:0] MinEdgesReset  = TicksW'(10);

  localparam int unsigned DefaultHistoryDepth = 4;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMinPeriod = 2'd0,
    CfgMinEdges  = 2'd1,
    CfgFake      = 2'd2
  } cfg_reg_e;

  // Input commands
  typedef enum logic {
    CmdCapture = 1'b0,
    CmdUpdate  = 1'b1
  } cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StFinish
  } state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_stat_t;

endpackage
`default_nettype wire

@@ hdl/ptc_if.sv @@
`default_nettype none
// Input channel: capture and update transactions
interface ptc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [ptc_pkg::TicksW-1:0]  capture_ticks;

  modport source (output valid, command, capture_ticks, input ready);
  modport sink   (input valid, command, capture_ticks, output ready);
endinterface

// Output channel: one result transaction per update
interface ptc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptc_pkg::SpeedW-1:0]  speed_x40;
  logic [ptc_pkg::SampleW-1:0] instant_speed;

  modport source (output valid, speed_x40, instant_speed, input ready);
  modport sink   (input valid, speed_x40, instant_speed, output ready);
endinterface
`default_nettype wire

@@ hdl/ptc_divider.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle: TicksNumerator / divisor
module ptc_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ptc_pkg::TicksW-1:0] divisor_i,
  output ptc_pkg::div_stat_t              stat_o
);
  import ptc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [TicksW-1:0]   rem_q, rem_d;
  logic [QuotW-1:0]    quot_q, quot_d;
  logic [TicksW-1:0]   div_q, div_d;
  logic [TicksW:0]     rem_shift;
  logic [TicksW+1:0]   diff;

  // One shift-subtract step
  always_comb begin
    rem_shift = {rem_q, quot_q[QuotW-1]};
    diff      = {1'b0, rem_shift} - {2'b00, div_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    div_d     = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = TicksNumerator;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[TicksW+1]) begin
        rem_d  = rem_shift[TicksW-1:0];
        quot_d = {quot_q[QuotW-2:0], 1'b0};
      end else begin
        rem_d  = diff[TicksW-1:0];
        quot_d = {quot_q[QuotW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(QuotW-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quot_q;

endmodule
`default_nettype wire

@@ hdl/period_capture_tachometer.sv @@
`default_nettype none
// Period-capture tachometer. A capture transaction stores a pulse period and
// bumps a wrapping edge counter. An update transaction forms a speed sample
// 2*(160000000/period), saturated at 65535 (or 0 if too few new edges or too
// short a period), writes it into a ring of HISTORY_DEPTH entries and returns
// the ring sum (rpm times 40; 40000 in fake mode) along with the sample. An
// update that divides is accepted, then the serial divider produces one of 28
// quotient bits per cycle, then the result is handed off and written to the
// ring. An update with a zero sample skips the divider. The input is not ready
// while an update is in progress; a finished result waits in an output
// register, and the next transaction is taken while it waits. The ring sum is
// kept as a running total, so no pass over the ring is needed.
module period_capture_tachometer #(
  parameter int unsigned HISTORY_DEPTH = ptc_pkg::DefaultHistoryDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ptc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ptc_pkg::CfgDataW-1:0] cfg_data_i,
  ptc_in_if.sink                            items_i,
  ptc_out_if.source                         results_o
);
  import ptc_pkg::*;

  localparam int unsigned SlotW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SumW  = SampleW + $clog2(HISTORY_DEPTH + 1);

  // Configuration
  logic [TicksW-1:0] min_period_q;
  logic [TicksW-1:0] min_edges_q;
  logic              fake_q;

  // Measurement state
  state_e            state_q, state_d;
  logic [TicksW-1:0] last_period_q;
  logic [TicksW-1:0] edge_count_q;
  logic [TicksW-1:0] edges_at_update_q;
  logic [SampleW-1:0] hist_q [HISTORY_DEPTH];
  logic [SlotW-1:0]  slot_q;
  logic [SumW-1:0]   sum_q;
  logic [SampleW-1:0] sample_q, sample_d;

  // Output register
  logic               out_valid_q;
  logic [SpeedW-1:0]  out_speed_q;
  logic [SampleW-1:0] out_sample_q;

  logic               accept;
  logic               is_update;
  logic [TicksW-1:0]  new_edges;
  logic               edges_ok;
  logic               period_ok;
  logic               div_start;
  logic               load_out;
  logic [SumW-1:0]    sum_next;
  logic [SpeedW-1:0]  speed_next;
  div_stat_t          div_stat;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q <= MinPeriodReset;
      min_edges_q  <= MinEdgesReset;
      fake_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinPeriod: min_period_q <= cfg_data_i[TicksW-1:0];
        CfgMinEdges:  min_edges_q  <= cfg_data_i[TicksW-1:0];
        CfgFake:      fake_q       <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // Update qualification
  assign items_i.ready = (state_q == StIdle);
  assign accept    = items_i.valid && items_i.ready;
  assign is_update = (items_i.command == CmdUpdate);
  assign new_edges = edge_count_q - edges_at_update_q;
  assign edges_ok  = (new_edges > min_edges_q);
  assign period_ok = (last_period_q > min_period_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && is_update) begin
          state_d = (edges_ok && period_ok) ? StDivide : StFinish;
        end
      end
      StDivide: begin
        if (div_stat.done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_start     = 1'b0;
    load_out      = 1'b0;
    sample_d      = sample_q;
    unique case (state_q)
      StIdle: begin
        div_start     = accept && is_update && edges_ok && period_ok;
        if (accept && is_update) begin
          sample_d = '0;
        end
      end
      StDivide: begin
        if (div_stat.done) begin
          // 2*q saturates once q reaches 2^15
          if (|div_stat.quot[QuotW-1:SampleW-1]) begin
            sample_d = SampleMax;
          end else begin
            sample_d = {div_stat.quot[SampleW-2:0], 1'b0};
          end
        end
      end
      StFinish: begin
        load_out = !out_valid_q || results_o.ready;
      end
      default: ;
    endcase
  end

  // Running ring sum and reported speed
  always_comb begin
    sum_next = sum_q - SumW'(hist_q[slot_q]) + SumW'(sample_q);
    if (sum_next > SumW'(SpeedMax)) begin
      speed_next = SpeedMax;
    end else begin
      speed_next = SpeedW'(sum_next);
    end
    if (fake_q) begin
      speed_next = FakeSpeedX40;
    end
  end

  ptc_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (last_period_q),
    .stat_o    (div_stat)
  );

  // State, counters and ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= StIdle;
      last_period_q     <= '0;
      edge_count_q      <= '0;
      edges_at_update_q <= '0;
      slot_q            <= '0;
      sum_q             <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept && !is_update) begin
        last_period_q <= items_i.capture_ticks;
        edge_count_q  <= edge_count_q + 1'b1;
      end
      if (accept && is_update && edges_ok) begin
        edges_at_update_q <= edge_count_q;
      end
      if (load_out) begin
        hist_q[slot_q] <= sample_q;
        sum_q          <= sum_next;
        slot_q         <= (slot_q == SlotW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (results_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_speed_q  <= speed_next;
      out_sample_q <= sample_q;
    end
  end

  assign results_o.valid         = out_valid_q;
  assign results_o.speed_x40     = out_speed_q;
  assign results_o.instant_speed = out_sample_q;

  // Checks
  a_start_to_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == StDivide)
    else $error("divider start did not enter divide state");

  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == StDivide)
    else $error("divider done outside divide state");

  a_fake_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && fake_q |=> results_o.speed_x40 == FakeSpeedX40)
    else $error("fake mode speed not forced");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SumW'(HISTORY_DEPTH * 65535))
    else $error("ring sum exceeds ring capacity");

endmodule
`default_nettype wire

@@ dv/tacho_speed_check.sv @@
// Watches the tachometer channels, keeps its own copy of the speed state and
// compares every result transaction against the oldest predicted report.
module tacho_speed_check #(
  parameter int unsigned HISTORY_DEPTH = ptc_pkg::DefaultHistoryDepth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ptc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ptc_pkg::CfgDataW-1:0] cfg_data_i,
  ptc_in_if                                 items_mon,
  ptc_out_if                                results_mon,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int unsigned PrintCap = 200;

  typedef struct packed {
    logic [SpeedW-1:0]  speed_x40;
    logic [SampleW-1:0] instant_speed;
  } speed_report_t;

  speed_report_t expected_reports[$];

  // Shadow configuration
  logic [TicksW-1:0]  min_period;
  logic [TicksW-1:0]  min_edges;
  logic               fake_on;

  // Shadow tachometer state
  logic [TicksW-1:0]  last_period;
  logic [TicksW-1:0]  edge_count;
  logic [TicksW-1:0]  edges_at_update;
  logic [SampleW-1:0] history [HISTORY_DEPTH];
  int unsigned        slot;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count_o < PrintCap) begin
      $display("%0t ns  MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  // Forms one speed sample, pushes it into the ring and returns the report
  function automatic speed_report_t predict_update();
    speed_report_t     rep;
    logic [TicksW-1:0] fresh_edges;
    logic [31:0]       speed_sample;
    logic [31:0]       ring_sum;
    speed_sample = '0;
    // Edge difference wraps at 16 bits
    fresh_edges = edge_count - edges_at_update;
    if (fresh_edges > min_edges) begin
      edges_at_update = edge_count;
      // A zero period never exceeds the floor, so no divide by zero here
      if (last_period > min_period) begin
        speed_sample = (32'(TicksNumerator) / 32'(last_period)) * 2;
        if (speed_sample > 32'(SampleMax)) begin
          speed_sample = 32'(SampleMax);
        end
      end
    end
    history[slot] = speed_sample[SampleW-1:0];
    slot = (slot + 1 >= HISTORY_DEPTH) ? 0 : slot + 1;
    ring_sum = '0;
    foreach (history[i]) begin
      ring_sum += 32'(history[i]);
    end
    if (ring_sum > 32'(SpeedMax)) begin
      ring_sum = 32'(SpeedMax);
    end
    rep.speed_x40     = fake_on ? FakeSpeedX40 : ring_sum[SpeedW-1:0];
    rep.instant_speed = speed_sample[SampleW-1:0];
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    speed_report_t want;
    if (!rst_ni) begin
      min_period      = MinPeriodReset;
      min_edges       = MinEdgesReset;
      fake_on         = 1'b0;
      last_period     = '0;
      edge_count      = '0;
      edges_at_update = '0;
      foreach (history[i]) begin
        history[i] = '0;
      end
      slot = 0;
      expected_reports.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CfgMinPeriod: min_period = cfg_data_i;
          CfgMinEdges:  min_edges  = cfg_data_i;
          CfgFake:      fake_on    = cfg_data_i[0];
          default: ;
        endcase
      end

      // Result transaction against the oldest expectation
      if (results_mon.valid && results_mon.ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with no update outstanding",
                          32'(results_mon.speed_x40), '0);
        end else begin
          want = expected_reports.pop_front();
          if (results_mon.speed_x40 !== want.speed_x40) begin
            report_mismatch("speed_x40", 32'(results_mon.speed_x40), 32'(want.speed_x40));
          end
          if (results_mon.instant_speed !== want.instant_speed) begin
            report_mismatch("instant_speed", 32'(results_mon.instant_speed),
                            32'(want.instant_speed));
          end
        end
      end

      // Input transaction
      if (items_mon.valid && items_mon.ready) begin
        if (cmd_e'(items_mon.command) == CmdCapture) begin
          last_period = items_mon.capture_ticks;
          edge_count  = edge_count + 1'b1;
        end else begin
          expected_reports.push_back(predict_update());
        end
      end

      pending_o = expected_reports.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Stimulus and verdict for the period-capture tachometer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int unsigned ClkPeriod      = 20;
  localparam int unsigned ResetCycles    = 5;
  localparam int unsigned MaxGap         = 14;
  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned RandomItems    = 1850;
  localparam int unsigned RandomPhases   = 12;
  localparam int unsigned PressurePhase  = 3;
  localparam int unsigned LimitCycles    = 2000000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         fail_count;
  int unsigned         pending;

  // Stimulus bookkeeping; the phase flags are shared by the two sides
  bit                  quiet_phase   = 1'b0;
  bit                  long_hold_req = 1'b0;
  int unsigned         items_sent    = 0;
  int unsigned         cur_min_period = MinPeriodReset;
  int unsigned         cur_min_edges  = MinEdgesReset;

  ptc_in_if  items_if ();
  ptc_out_if results_if ();

  period_capture_tachometer #(
    .HISTORY_DEPTH(DefaultHistoryDepth)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .items_i   (items_if),
    .results_o (results_if)
  );

  tacho_speed_check #(
    .HISTORY_DEPTH(DefaultHistoryDepth)
  ) speed_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .items_mon   (items_if),
    .results_mon (results_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return quiet_phase ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Periods around the floor, the saturation knee and the extremes
  function automatic logic [TicksW-1:0] pick_period();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return TicksW'(cur_min_period);
      2:       return TicksW'(cur_min_period + 1);
      3:       return TicksW'($urandom_range(4878, 4890));
      4:       return '1;
      default: return TicksW'($urandom);
    endcase
  endfunction

  // One input transaction after a random gap
  task automatic send_item(input cmd_e cmd, input logic [TicksW-1:0] ticks);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    items_if.valid         <= 1'b1;
    items_if.command       <= cmd;
    items_if.capture_ticks <= ticks;
    @(posedge clk_i);
    while (!items_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop sending and let every outstanding update come back
  task automatic drain();
    items_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [TicksW-1:0] period_floor,
                           input logic [TicksW-1:0] edge_floor,
                           input logic fake_mode, input bit poke_unused);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgMinPeriod;
    cfg_data <= period_floor;
    @(posedge clk_i);
    cfg_idx  <= CfgMinEdges;
    cfg_data <= edge_floor;
    @(posedge clk_i);
    // only bit 0 of the fake register is meaningful
    cfg_idx  <= CfgFake;
    cfg_data <= {15'($urandom), fake_mode};
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_idx  <= CfgUnused;
      cfg_data <= CfgDataW'($urandom);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cur_min_period = period_floor;
    cur_min_edges  = edge_floor;
  endtask

  // Mostly capture runs long enough to pass the edge filter, then an update
  task automatic run_random_phase(input int unsigned count);
    int unsigned stop_at;
    int unsigned runs;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          runs = (cur_min_edges < 32) ? cur_min_edges + 1 + $urandom_range(0, 3)
                                      : $urandom_range(0, 6);
          repeat (runs) send_item(CmdCapture, pick_period());
          send_item(CmdUpdate, TicksW'($urandom));
        end
        7, 8: begin
          runs = $urandom_range(0, 3);
          repeat (runs) send_item(CmdCapture, pick_period());
          send_item(CmdUpdate, TicksW'($urandom));
        end
        default: send_item(cmd_e'($urandom_range(0, 1)), TicksW'($urandom));
      endcase
    end
  endtask

  // Result side: random stalls, and one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    results_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LongHoldCycles;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      results_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!results_if.valid) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic [TicksW-1:0] period_floor;
    logic [TicksW-1:0] edge_floor;
    rst_ni                 <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_idx                <= CfgMinPeriod;
    cfg_data               <= '0;
    items_if.valid         <= 1'b0;
    items_if.command       <= CmdCapture;
    items_if.capture_ticks <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: update with no edges, then with a single edge
    send_item(CmdUpdate, '1);
    send_item(CmdCapture, '1);
    send_item(CmdUpdate, '0);

    // Lowest floors
    drain();
    configure('0, '0, 1'b0, 1'b1);
    // zero period never divides
    send_item(CmdCapture, '0);
    send_item(CmdUpdate, '0);
    // shortest period saturates the sample
    send_item(CmdCapture, 16'd1);
    send_item(CmdUpdate, '1);
    send_item(CmdCapture, '1);
    send_item(CmdUpdate, '0);
    // no new edge since the last update
    send_item(CmdUpdate, '1);
    // just below saturation
    send_item(CmdCapture, 16'd4883);
    send_item(CmdUpdate, '0);

    // Highest period floor with fake mode on
    drain();
    configure('1, '0, 1'b1, 1'b0);
    send_item(CmdCapture, '1);
    send_item(CmdUpdate, '0);
    send_item(CmdCapture, 16'd40000);
    send_item(CmdUpdate, '1);

    // Edge filter that can never pass
    drain();
    configure(MinPeriodReset, '1, 1'b0, 1'b0);
    send_item(CmdCapture, 16'd5000);
    send_item(CmdUpdate, '0);

    // Random phases with fresh settings each time
    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain();
      case ($urandom_range(0, 4))
        0:       period_floor = '0;
        1:       period_floor = MinPeriodReset;
        2:       period_floor = '1;
        3:       period_floor = TicksW'($urandom_range(1, 8000));
        default: period_floor = TicksW'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       edge_floor = '0;
        1:       edge_floor = MinEdgesReset;
        2:       edge_floor = '1;
        3:       edge_floor = TicksW'($urandom);
        default: edge_floor = TicksW'($urandom_range(1, 8));
      endcase
      if (phase == PressurePhase) begin
        // long result stall while inputs keep coming
        period_floor = '0;
        edge_floor   = '0;
      end
      configure(period_floor, edge_floor, ($urandom_range(0, 3) == 0), (phase % 4 == 1));
      quiet_phase = (phase != PressurePhase) && ($urandom_range(0, 3) == 0);
      if (phase == PressurePhase) begin
        long_hold_req = 1'b1;
      end
      run_random_phase(RandomItems / RandomPhases);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("period_capture_tachometer regression: pass");
    end else begin
      $display("period_capture_tachometer regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(LimitCycles * ClkPeriod);
    $display("period_capture_tachometer regression: fail");
    $finish;
  end

endmodule

@@ period_capture_tachometer.f @@
hdl/ptc_pkg.sv
hdl/ptc_if.sv
hdl/ptc_divider.sv
hdl/period_capture_tachometer.sv
dv/tacho_speed_check.sv
dv/tb.sv
